@@ design/lts_pkg.sv @@
`timescale 1ns / 1ps

package lts_pkg;

    // Default sample width for the light inputs.
    localparam int SAMPLE_WIDTH_DEF = 8;

    // Configuration port geometry.
    localparam int CFG_INDEX_WIDTH = 3;
    localparam int CFG_DATA_WIDTH  = 16;

    // Configuration register indexes.
    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_DEADBAND  = 3'd0;
    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_POS_MIN   = 3'd1;
    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_POS_MAX   = 3'd2;
    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_TICKS     = 3'd3;
    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_FRAME     = 3'd4;

    // Reset values of the configuration registers.
    localparam logic [7:0]  DEADBAND_RST = 8'd14;
    localparam logic [7:0]  POS_MIN_RST  = 8'd40;
    localparam logic [7:0]  POS_MAX_RST  = 8'd192;
    localparam logic [7:0]  TICKS_RST    = 8'd12;
    localparam logic [15:0] FRAME_RST    = 16'd20000;

    // Reset values of the tracker state.
    localparam logic [7:0] POSITION_RST = 8'd112;
    localparam logic [7:0] SPEED_RST    = 8'd1;
    localparam logic [7:0] REPORTED_RST = 8'd0;

    // Step direction codes.
    localparam logic [1:0] DIR_NONE  = 2'd0;
    localparam logic [1:0] DIR_LEFT  = 2'd1;
    localparam logic [1:0] DIR_RIGHT = 2'd2;

    // Action codes of a result.
    localparam logic [1:0] ACT_HOLD    = 2'd0;
    localparam logic [1:0] ACT_LEFT    = 2'd1;
    localparam logic [1:0] ACT_RIGHT   = 2'd2;
    localparam logic [1:0] ACT_REFUSED = 2'd3;

    // Tracker state carried from one request to the next.
    typedef struct packed {
        logic [7:0] position;
        logic [7:0] speed;
        logic [1:0] dir;
        logic [7:0] reported;
    } t_servo_state;

    // Configuration registers as seen by the datapath.
    typedef struct packed {
        logic [7:0]  deadband;
        logic [7:0]  pos_min;
        logic [7:0]  pos_max;
        logic [7:0]  ticks;
        logic [15:0] frame;
    } t_servo_cfg;

    // One result.
    typedef struct packed {
        logic [7:0]  position;
        logic [15:0] pulse_high;
        logic [15:0] pulse_low;
        logic        report;
        logic [1:0]  action;
    } t_servo_result;

endpackage

@@ design/lts_step_core.sv @@
`timescale 1ns / 1ps

module lts_step_core
    import lts_pkg::*;
#(
    parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF
) (
    input  logic [SAMPLE_WIDTH-1:0] i_sample_one,
    input  logic [SAMPLE_WIDTH-1:0] i_sample_two,
    input  logic [SAMPLE_WIDTH-1:0] i_sample_three,
    input  logic [SAMPLE_WIDTH-1:0] i_sample_four,
    input  t_servo_cfg              i_cfg,
    input  t_servo_state            i_state,
    output t_servo_state            o_state,
    output t_servo_result           o_result
);

    logic [SAMPLE_WIDTH:0]   sum_left;
    logic [SAMPLE_WIDTH:0]   sum_right;
    logic [SAMPLE_WIDTH-1:0] left;
    logic [SAMPLE_WIDTH-1:0] right;
    logic [SAMPLE_WIDTH-1:0] mag;
    logic [SAMPLE_WIDTH-1:0] deadband_ext;
    logic                    right_lt;
    logic                    left_lt;
    logic                    settled;
    logic [1:0]              step_dir;
    logic [7:0]              step_speed;
    logic [7:0]              cand;
    logic                    cand_ok;
    logic [15:0]             pulse_high;

    // Floored means of each side and the magnitude of their difference.
    assign sum_left     = {1'b0, i_sample_one} + {1'b0, i_sample_three};
    assign sum_right    = {1'b0, i_sample_two} + {1'b0, i_sample_four};
    assign left         = sum_left[SAMPLE_WIDTH:1];
    assign right        = sum_right[SAMPLE_WIDTH:1];
    assign right_lt     = right < left;
    assign left_lt      = left < right;
    assign mag          = left_lt ? (right - left) : (left - right);
    assign deadband_ext = SAMPLE_WIDTH'(i_cfg.deadband);
    assign settled      = (mag != '0) && (mag < deadband_ext);

    // Candidate step: speed ramps while the direction repeats.
    assign step_dir   = right_lt ? DIR_LEFT : DIR_RIGHT;
    assign step_speed = (i_state.dir == step_dir) ? (i_state.speed + 8'd1) : 8'd1;
    assign cand       = right_lt ? (i_state.position + step_speed)
                                 : (i_state.position - step_speed);
    assign cand_ok    = (cand >= i_cfg.pos_min) && (cand <= i_cfg.pos_max);

    // State update, action code and pulse timing.
    always_comb begin
        o_state         = i_state;
        o_result.report = 1'b0;
        o_result.action = ACT_HOLD;
        priority if (settled) begin
            if (i_state.reported != i_state.position) begin
                o_state.reported = i_state.position;
                o_result.report  = 1'b1;
            end
        end else if (right_lt || left_lt) begin
            o_state.speed = step_speed;
            o_state.dir   = step_dir;
            if (cand_ok) begin
                o_state.position = cand;
                o_result.action  = right_lt ? ACT_LEFT : ACT_RIGHT;
            end else begin
                o_result.action  = ACT_REFUSED;
            end
        end else begin
            o_result.action = ACT_HOLD;
        end

        // Pulse timing from the new position; the low time floors at zero.
        pulse_high          = {8'd0, o_state.position} * {8'd0, i_cfg.ticks};
        o_result.position   = o_state.position;
        o_result.pulse_high = pulse_high;
        o_result.pulse_low  = (i_cfg.frame > pulse_high) ? (i_cfg.frame - pulse_high)
                                                         : 16'd0;
    end

endmodule

@@ design/light_tracker_servo_step.sv @@
`timescale 1ns / 1ps

// Channel   Direction  Handshake               Payload
// input     in         i_in_valid / o_in_stall  i_sample_one .. i_sample_four
// result    out        o_out_valid / i_out_stall o_servo_position, o_pulse_high_ticks,
//                                                o_pulse_low_ticks, o_report_valid, o_action
// config    in         i_cfg_we                 i_cfg_index, i_cfg_data
//
// A request enters the input register, then passes through the datapath into the
// result register, where it waits to be taken; one request per cycle while the result side does not stall.
// The tracker state is updated in the same cycle the result register loads,
// so the next request sees it with no bubble.
// Reset is synchronous and active low; it restores the configuration registers, the valid flags and the state.
// A stalled result holds the result register; the input side stalls once a request waits in the input register.
module light_tracker_servo_step
    import lts_pkg::*;
#(
    parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_in_valid,
    output logic                       o_in_stall,
    input  logic [SAMPLE_WIDTH-1:0]    i_sample_one,
    input  logic [SAMPLE_WIDTH-1:0]    i_sample_two,
    input  logic [SAMPLE_WIDTH-1:0]    i_sample_three,
    input  logic [SAMPLE_WIDTH-1:0]    i_sample_four,
    output logic                       o_out_valid,
    input  logic                       i_out_stall,
    output logic [7:0]                 o_servo_position,
    output logic [15:0]                o_pulse_high_ticks,
    output logic [15:0]                o_pulse_low_ticks,
    output logic                       o_report_valid,
    output logic [1:0]                 o_action,
    input  logic                       i_cfg_we,
    input  logic [CFG_INDEX_WIDTH-1:0] i_cfg_index,
    input  logic [CFG_DATA_WIDTH-1:0]  i_cfg_data
);

    logic                    r_in_valid;
    logic [SAMPLE_WIDTH-1:0] r_s1;
    logic [SAMPLE_WIDTH-1:0] r_s2;
    logic [SAMPLE_WIDTH-1:0] r_s3;
    logic [SAMPLE_WIDTH-1:0] r_s4;
    logic                    r_out_valid;
    t_servo_result           r_out;
    t_servo_state            r_state;
    t_servo_cfg              r_cfg;
    t_servo_state            n_state;
    t_servo_result           n_out;
    logic                    out_free;
    logic                    advance;
    logic                    in_take;

    // Handshake: the result register frees when empty or being taken.
    assign out_free   = !r_out_valid || !i_out_stall;
    assign advance    = r_in_valid && out_free;
    assign o_in_stall = r_in_valid && !out_free;
    assign in_take    = i_in_valid && !o_in_stall;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.deadband <= DEADBAND_RST;
            r_cfg.pos_min  <= POS_MIN_RST;
            r_cfg.pos_max  <= POS_MAX_RST;
            r_cfg.ticks    <= TICKS_RST;
            r_cfg.frame    <= FRAME_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_DEADBAND: r_cfg.deadband <= i_cfg_data[7:0];
                CFG_POS_MIN:  r_cfg.pos_min  <= i_cfg_data[7:0];
                CFG_POS_MAX:  r_cfg.pos_max  <= i_cfg_data[7:0];
                CFG_TICKS:    r_cfg.ticks    <= i_cfg_data[7:0];
                CFG_FRAME:    r_cfg.frame    <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // Input register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_in_stall) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_s1 <= i_sample_one;
            r_s2 <= i_sample_two;
            r_s3 <= i_sample_three;
            r_s4 <= i_sample_four;
        end
    end

    // Tracker datapath.
    lts_step_core #(
        .SAMPLE_WIDTH (SAMPLE_WIDTH)
    ) u_core (
        .i_sample_one   (r_s1),
        .i_sample_two   (r_s2),
        .i_sample_three (r_s3),
        .i_sample_four  (r_s4),
        .i_cfg          (r_cfg),
        .i_state        (r_state),
        .o_state        (n_state),
        .o_result       (n_out)
    );

    // Tracker state and result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state.position <= POSITION_RST;
            r_state.speed    <= SPEED_RST;
            r_state.dir      <= DIR_NONE;
            r_state.reported <= REPORTED_RST;
            r_out_valid      <= 1'b0;
        end else begin
            if (advance) begin
                r_state <= n_state;
            end
            if (out_free) begin
                r_out_valid <= r_in_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid        = r_out_valid;
    assign o_servo_position   = r_out.position;
    assign o_pulse_high_ticks = r_out.pulse_high;
    assign o_pulse_low_ticks  = r_out.pulse_low;
    assign o_report_valid     = r_out.report;
    assign o_action           = r_out.action;

`ifndef ASSERT_OFF
    // The input side stalls only while a request sits in the input register.
    a_stall_needs_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_in_valid |-> !o_in_stall)
        else $error("input stall without a pending request");

    // A report happens only on a settled request, which never moves.
    a_report_is_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.report) |-> (r_out.action == ACT_HOLD))
        else $error("report raised on a stepping request");

    // An accepted move lands inside the position limits.
    a_move_in_limits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && (r_out.action == ACT_LEFT || r_out.action == ACT_RIGHT))
        |-> (r_out.position >= r_cfg.pos_min && r_out.position <= r_cfg.pos_max))
        else $error("moved position outside limits");

    // High and low times fill the frame unless the low time saturated.
    a_frame_split: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_out.pulse_low == 16'd0 ||
            ({1'b0, r_out.pulse_low} + {1'b0, r_out.pulse_high}) == {1'b0, r_cfg.frame}))
        else $error("pulse times do not add up to the frame");

    // The result position follows the tracker state after the update.
    a_position_tracks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance |=> (r_out.position == r_state.position))
        else $error("result position differs from tracker state");
`endif

endmodule

@@ bench/tb.sv @@
`timescale 1ns / 1ps

module tb
    import lts_pkg::*;
;

    localparam int QUIET_LIMIT = 2000;
    localparam int REPORT_LIMIT = 10;

    // Tracks the servo state and configuration, and holds the predicted results in order.
    class servo_scoreboard;
        t_servo_cfg    cfg;
        t_servo_state  st;
        t_servo_result expected_servo_results[$];
        int            failures;

        function new();
            cfg.deadband = DEADBAND_RST;
            cfg.pos_min  = POS_MIN_RST;
            cfg.pos_max  = POS_MAX_RST;
            cfg.ticks    = TICKS_RST;
            cfg.frame    = FRAME_RST;
            st.position  = POSITION_RST;
            st.speed     = SPEED_RST;
            st.dir       = DIR_NONE;
            st.reported  = REPORTED_RST;
            failures     = 0;
        endfunction

        // Mirror a register write; spare indexes have no effect.
        function void write_register(input logic [CFG_INDEX_WIDTH-1:0] index,
                                     input logic [CFG_DATA_WIDTH-1:0] data);
            case (index)
                CFG_DEADBAND: cfg.deadband = data[7:0];
                CFG_POS_MIN:  cfg.pos_min  = data[7:0];
                CFG_POS_MAX:  cfg.pos_max  = data[7:0];
                CFG_TICKS:    cfg.ticks    = data[7:0];
                CFG_FRAME:    cfg.frame    = data[15:0];
                default: ;
            endcase
        endfunction

        // Work out the servo step caused by one accepted request.
        function void note_light_request(input logic [7:0] s1, s2, s3, s4);
            logic [8:0]    left_sum, right_sum;
            logic [7:0]    left, right, mag, cand;
            logic [1:0]    dir;
            t_servo_result want;
            left_sum  = s1 + s3;
            right_sum = s2 + s4;
            left  = left_sum[8:1];
            right = right_sum[8:1];
            mag   = (right > left) ? right - left : left - right;
            want.action = ACT_HOLD;
            want.report = 1'b0;
            dir = DIR_NONE;
            if (mag != 8'd0 && mag < cfg.deadband) begin
                // Settled: report only a position not reported before.
                if (st.reported != st.position) begin
                    st.reported = st.position;
                    want.report = 1'b1;
                end
            end else if (right < left) begin
                dir = DIR_LEFT;
            end else if (left < right) begin
                dir = DIR_RIGHT;
            end
            // A step accelerates in the same direction and may be refused by the limits.
            if (dir != DIR_NONE) begin
                st.speed = (st.dir == dir) ? st.speed + 8'd1 : 8'd1;
                st.dir = dir;
                cand = (dir == DIR_LEFT) ? st.position + st.speed : st.position - st.speed;
                if (cand >= cfg.pos_min && cand <= cfg.pos_max) begin
                    st.position = cand;
                    want.action = (dir == DIR_LEFT) ? ACT_LEFT : ACT_RIGHT;
                end else begin
                    want.action = ACT_REFUSED;
                end
            end
            want.position   = st.position;
            want.pulse_high = st.position * cfg.ticks;
            want.pulse_low  = (cfg.frame > want.pulse_high) ? cfg.frame - want.pulse_high
                                                            : 16'd0;
            expected_servo_results.push_back(want);
        endfunction

        // Compare one accepted result with the oldest prediction.
        function void check_result(input t_servo_result seen);
            t_servo_result want;
            if (expected_servo_results.size() == 0) begin
                failures++;
                if (failures <= REPORT_LIMIT)
                    $display("%0t: result with no request pending: pos %0d high %0d low %0d rep %0b act %0d",
                             $realtime, seen.position, seen.pulse_high, seen.pulse_low,
                             seen.report, seen.action);
            end else begin
                want = expected_servo_results.pop_front();
                if (want.position !== seen.position || want.pulse_high !== seen.pulse_high ||
                    want.pulse_low !== seen.pulse_low || want.report !== seen.report ||
                    want.action !== seen.action) begin
                    failures++;
                    if (failures <= REPORT_LIMIT)
                        $display("%0t: expected pos %0d high %0d low %0d rep %0b act %0d, got pos %0d high %0d low %0d rep %0b act %0d",
                                 $realtime, want.position, want.pulse_high, want.pulse_low,
                                 want.report, want.action, seen.position, seen.pulse_high,
                                 seen.pulse_low, seen.report, seen.action);
                end
            end
        endfunction
    endclass

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_in_valid = 1'b0;
    logic o_in_stall;
    logic [7:0] i_sample_one = 8'd0;
    logic [7:0] i_sample_two = 8'd0;
    logic [7:0] i_sample_three = 8'd0;
    logic [7:0] i_sample_four = 8'd0;
    logic o_out_valid;
    logic i_out_stall = 1'b0;
    logic [7:0] o_servo_position;
    logic [15:0] o_pulse_high_ticks;
    logic [15:0] o_pulse_low_ticks;
    logic o_report_valid;
    logic [1:0] o_action;
    logic i_cfg_we = 1'b0;
    logic [CFG_INDEX_WIDTH-1:0] i_cfg_index = CFG_DEADBAND;
    logic [CFG_DATA_WIDTH-1:0] i_cfg_data = '0;

    servo_scoreboard sb;
    t_servo_result seen_result;
    bit no_idle = 1'b0;
    int quiet_cycles = 0;

    assign seen_result = {o_servo_position, o_pulse_high_ticks, o_pulse_low_ticks,
                          o_report_valid, o_action};

    light_tracker_servo_step i_dut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_in_valid         (i_in_valid),
        .o_in_stall         (o_in_stall),
        .i_sample_one       (i_sample_one),
        .i_sample_two       (i_sample_two),
        .i_sample_three     (i_sample_three),
        .i_sample_four      (i_sample_four),
        .o_out_valid        (o_out_valid),
        .i_out_stall        (i_out_stall),
        .o_servo_position   (o_servo_position),
        .o_pulse_high_ticks (o_pulse_high_ticks),
        .o_pulse_low_ticks  (o_pulse_low_ticks),
        .o_report_valid     (o_report_valid),
        .o_action           (o_action),
        .i_cfg_we           (i_cfg_we),
        .i_cfg_index        (i_cfg_index),
        .i_cfg_data         (i_cfg_data)
    );

    always #5 i_clk = ~i_clk;

    // Note accepted requests and check accepted results.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_in_valid && !o_in_stall)
                sb.note_light_request(i_sample_one, i_sample_two, i_sample_three, i_sample_four);
            if (o_out_valid && !i_out_stall)
                sb.check_result(seen_result);
        end
    end

    // Give up when nothing moves for too long.
    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall) || i_cfg_we) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles == QUIET_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Stall the result side for a random number of cycles before each result.
    initial begin : result_pacing
        int wait_cycles;
        @(posedge i_rst_n);
        forever begin
            wait_cycles = no_idle ? 0 : $urandom_range(0, 14);
            if (wait_cycles > 0) begin
                i_out_stall <= 1'b1;
                repeat (wait_cycles) @(posedge i_clk);
                i_out_stall <= 1'b0;
            end
            do @(posedge i_clk); while (o_out_valid !== 1'b1);
        end
    end

    // Present one request after a random gap and hold it until accepted.
    task automatic send_request(input logic [31:0] samples);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 14);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        {i_sample_one, i_sample_two, i_sample_three, i_sample_four} <= samples;
        do @(posedge i_clk); while (o_in_stall !== 1'b0);
    endtask

    // Stop sending and wait until every predicted result has come back.
    task automatic drain_results();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (sb.expected_servo_results.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    // The write enable stays high across a group of writes; the caller lowers it.
    task automatic write_config(input logic [CFG_INDEX_WIDTH-1:0] index,
                                input logic [CFG_DATA_WIDTH-1:0] data);
        i_cfg_we <= 1'b1;
        i_cfg_index <= index;
        i_cfg_data <= data;
        @(posedge i_clk);
        sb.write_register(index, data);
    endtask

    // Write all registers; bits above each register's width carry noise.
    task automatic apply_settings(input logic [7:0] deadband, pos_min, pos_max, ticks,
                                  input logic [15:0] frame, input bit spare);
        write_config(CFG_DEADBAND, {8'($urandom), deadband});
        write_config(CFG_POS_MIN, {8'($urandom), pos_min});
        write_config(CFG_POS_MAX, {8'($urandom), pos_max});
        write_config(CFG_TICKS, {8'($urandom), ticks});
        write_config(CFG_FRAME, frame);
        if (spare) begin
            for (int k = 1; k <= 3; k++)
                write_config(CFG_FRAME + 3'(k), 16'($urandom));
        end
        i_cfg_we <= 1'b0;
    endtask

    // Two samples whose floored mean is the given value.
    function automatic logic [15:0] split_mean(input int mean);
        int spread, lo, hi;
        spread = $urandom_range(0, (mean < 255 - mean) ? mean : 255 - mean);
        lo = mean - spread;
        hi = mean + spread;
        if (hi < 255 && $urandom_range(0, 1) == 1)
            hi++;
        return ($urandom_range(0, 1) == 1) ? {lo[7:0], hi[7:0]} : {hi[7:0], lo[7:0]};
    endfunction

    // Four samples whose right mean minus left mean is the given difference.
    function automatic logic [31:0] shaped_samples(input int diff);
        int left_mean, right_mean;
        logic [15:0] left_pair, right_pair;
        left_mean = $urandom_range(0, 255);
        right_mean = left_mean + diff;
        if (right_mean > 255) begin
            left_mean -= right_mean - 255;
            right_mean = 255;
        end else if (right_mean < 0) begin
            left_mean -= right_mean;
            right_mean = 0;
        end
        left_pair = split_mean(left_mean);
        right_pair = split_mean(right_mean);
        return {left_pair[15:8], right_pair[15:8], left_pair[7:0], right_pair[7:0]};
    endfunction

    // Random requests: steady runs, deadband edges, zero difference and noise.
    // A nonzero steady sign forces steps one way to drive the speed around.
    task automatic run_phase(input int count, input int steady_sign);
        int pick, mag, db, run_sign;
        logic [31:0] samples;
        run_sign = 1;
        for (int n = 0; n < count; n++) begin
            if (n % 40 == 0)
                no_idle = ($urandom_range(0, 3) == 0);
            if (n == count / 2)
                drain_results();
            if ($urandom_range(0, 19) == 0)
                run_sign = -run_sign;
            db = sb.cfg.deadband;
            pick = $urandom_range(0, 99);
            if (steady_sign != 0) begin
                mag = $urandom_range(1, 255);
                samples = (pick < 90) ? shaped_samples(steady_sign * mag) : shaped_samples(0);
            end else if (pick < 30) begin
                // Around the deadband edge, or well inside it.
                if ($urandom_range(0, 1) == 0)
                    mag = db + $urandom_range(0, 2) - 1;
                else
                    mag = $urandom_range(1, (db > 2) ? db - 1 : 1);
                if (mag < 1)
                    mag = 1;
                if (mag > 255)
                    mag = 255;
                samples = shaped_samples(($urandom_range(0, 1) == 0) ? mag : -mag);
            end else if (pick < 65) begin
                mag = $urandom_range((db < 1) ? 1 : db, 255);
                samples = shaped_samples(run_sign * mag);
            end else if (pick < 75) begin
                samples = shaped_samples(0);
            end else begin
                samples = $urandom;
            end
            send_request(samples);
        end
        no_idle = 1'b0;
    endtask

    initial begin : stimulus
        sb = new();
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed requests under the reset configuration.
        send_request({8'd0, 8'd0, 8'd0, 8'd0});
        send_request({8'd255, 8'd255, 8'd255, 8'd255});
        // Left steps speed up, then a right step starts over at speed one.
        send_request({8'd255, 8'd0, 8'd255, 8'd0});
        send_request({8'd255, 8'd0, 8'd255, 8'd0});
        send_request({8'd0, 8'd255, 8'd0, 8'd255});
        // Settled twice: the second time the position is already reported.
        send_request({8'd100, 8'd105, 8'd100, 8'd105});
        send_request({8'd100, 8'd105, 8'd100, 8'd105});
        // Floored means: a difference of one settles, a lone odd bit holds.
        send_request({8'd1, 8'd2, 8'd0, 8'd0});
        send_request({8'd1, 8'd0, 8'd0, 8'd0});
        send_request({8'd255, 8'd254, 8'd254, 8'd255});
        // A difference equal to the deadband steps, one below it settles.
        send_request({8'd100, 8'd114, 8'd100, 8'd114});
        send_request({8'd100, 8'd113, 8'd100, 8'd113});
        // Accelerate left until the upper limit refuses the step.
        repeat (13) send_request({8'd200, 8'd0, 8'd200, 8'd0});
        send_request({8'd0, 8'd200, 8'd0, 8'd200});

        // No deadband and open limits; a long left run wraps the speed to zero.
        drain_results();
        apply_settings(8'd0, 8'd0, 8'd255, 8'd255, 16'd0, 1'b1);
        run_phase(300, -1);
        run_phase(60, 1);

        // Widest deadband with inverted limits: every step is refused.
        drain_results();
        apply_settings(8'd255, 8'd200, 8'd50, 8'd1, 16'hFFFF, 1'b0);
        run_phase(150, 0);

        // Narrowest deadband with both limits at zero.
        drain_results();
        apply_settings(8'd1, 8'd0, 8'd0, 8'd255, 16'hFFFF, 1'b1);
        run_phase(100, 0);

        // Back to the reset values.
        drain_results();
        apply_settings(DEADBAND_RST, POS_MIN_RST, POS_MAX_RST, TICKS_RST, FRAME_RST, 1'b0);
        run_phase(200, 0);

        // Random settings.
        for (int k = 0; k < 4; k++) begin
            drain_results();
            apply_settings((k == 0) ? 8'($urandom) : 8'($urandom_range(0, 40)),
                           8'($urandom_range(0, 120)), 8'($urandom_range(130, 255)),
                           8'($urandom), 16'($urandom), k[0]);
            run_phase(160, 0);
        end

        drain_results();
        repeat (10) @(posedge i_clk);
        if (sb.failures == 0 && sb.expected_servo_results.size() == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

@@ light_tracker_servo_step.f @@
design/lts_pkg.sv
design/lts_step_core.sv
design/light_tracker_servo_step.sv
bench/tb.sv
